// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold whenever the antecedent is true in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Property must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pcxrle_pkg.sv =====
// Types, constants and helpers for the run-length line encoder.
package pcxrle_pkg;

    localparam int MAX_RUN     = 63;
    localparam int COUNT_W     = $clog2(MAX_RUN + 1);
    localparam logic [7:0] HIGH_MARK = 8'hC0;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic               vld;
        logic [7:0]         value;
        logic [COUNT_W-1:0] count;
    } run_t;

    // One queued request: up to two finished runs and an optional pad byte.
    typedef struct packed {
        run_t run_a;
        run_t run_b;
        logic pad;
    } cmd_t;

    typedef enum logic [2:0] {
        STEP_A_PFX,
        STEP_A_VAL,
        STEP_B_PFX,
        STEP_B_VAL,
        STEP_PAD
    } step_t;

    function automatic logic need_prefix(run_t r);
        return (r.count > COUNT_W'(1)) || (r.value >= HIGH_MARK);
    endfunction

endpackage

// ===== rtl/pcxrle_front.sv =====
// Front end: accepts pixels, tracks the open run and issues emit requests.
`include "assert_macros.svh"

module pcxrle_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          pixel,
    input  logic                line_end,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data,
    input  logic                q_full,
    output logic                q_push,
    output pcxrle_pkg::cmd_t    q_cmd
);

    logic                           pad_line_reg;
    logic                           run_open_reg;
    logic                           run_open_next;
    logic [7:0]                     run_value_reg;
    logic [7:0]                     run_value_next;
    logic [pcxrle_pkg::COUNT_W-1:0] run_count_reg;
    logic [pcxrle_pkg::COUNT_W-1:0] run_count_next;
    logic                           accept;
    logic                           run_break;
    logic                           run_extend;
    logic [7:0]                     new_value;
    logic [pcxrle_pkg::COUNT_W-1:0] new_count;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;

    assign run_break  = run_open_reg &&
                        ((pixel != run_value_reg) ||
                         (run_count_reg >= pcxrle_pkg::COUNT_W'(pcxrle_pkg::MAX_RUN)));
    assign run_extend = run_open_reg && !run_break;

    always_comb
    begin
        if (run_extend)
        begin
            new_value = run_value_reg;
            new_count = run_count_reg + pcxrle_pkg::COUNT_W'(1);
        end
        else
        begin
            new_value = pixel;
            new_count = pcxrle_pkg::COUNT_W'(1);
        end

        q_cmd.run_a.vld   = run_break;
        q_cmd.run_a.value = run_value_reg;
        q_cmd.run_a.count = run_count_reg;
        q_cmd.run_b.vld   = line_end;
        q_cmd.run_b.value = new_value;
        q_cmd.run_b.count = new_count;
        q_cmd.pad         = line_end && pad_line_reg;

        q_push = accept && (run_break || line_end);

        run_open_next  = run_open_reg;
        run_value_next = run_value_reg;
        run_count_next = run_count_reg;
        if (accept)
        begin
            if (line_end)
            begin
                run_open_next  = 1'b0;
                run_value_next = 8'd0;
                run_count_next = '0;
            end
            else
            begin
                run_open_next  = 1'b1;
                run_value_next = new_value;
                run_count_next = new_count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_line_reg  <= 1'b0;
            run_open_reg  <= 1'b0;
            run_value_reg <= 8'd0;
            run_count_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                pad_line_reg <= cfg_data;
            end
            run_open_reg  <= run_open_next;
            run_value_reg <= run_value_next;
            run_count_reg <= run_count_next;
        end
    end

    `ASSERT_IMPLIES(a_open_count_range, run_open_reg,
        (run_count_reg != '0) &&
        (run_count_reg <= pcxrle_pkg::COUNT_W'(pcxrle_pkg::MAX_RUN)),
        "open run has an out-of-range count")
    `ASSERT_NEXT(a_line_end_closes, accept && line_end, !run_open_reg,
        "run still open after line end")

endmodule

// ===== rtl/pcxrle_queue.sv =====
// Short request queue between the front end and the byte sequencer.
`include "assert_macros.svh"

module pcxrle_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pcxrle_pkg::cmd_t    push_cmd,
    output logic                full,
    output logic                head_valid,
    output pcxrle_pkg::cmd_t    head,
    input  logic                pop
);

    pcxrle_pkg::cmd_t              entry_reg [pcxrle_pkg::QUEUE_DEPTH];
    logic [pcxrle_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [pcxrle_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [pcxrle_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [pcxrle_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [pcxrle_pkg::QCNT_W-1:0] count_reg;
    logic [pcxrle_pkg::QCNT_W-1:0] count_next;

    assign full       = (count_reg == pcxrle_pkg::QCNT_W'(pcxrle_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == pcxrle_pkg::QPTR_W'(pcxrle_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + pcxrle_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == pcxrle_pkg::QPTR_W'(pcxrle_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + pcxrle_pkg::QPTR_W'(1);
        end
        priority if (push && !pop)
        begin
            count_next = count_reg + pcxrle_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - pcxrle_pkg::QCNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `ASSERT_IMPLIES(a_no_overflow, push,
        count_reg < pcxrle_pkg::QCNT_W'(pcxrle_pkg::QUEUE_DEPTH),
        "push into a full queue")
    `ASSERT_IMPLIES(a_no_underflow, pop, count_reg != '0,
        "pop from an empty queue")

endmodule

// ===== rtl/pcxrle_back.sv =====
// Back end: expands queued requests into code bytes behind an output register.
`include "assert_macros.svh"

module pcxrle_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  pcxrle_pkg::cmd_t    head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          code_byte,
    output logic                last
);

    logic                   mid_reg;
    logic                   mid_next;
    pcxrle_pkg::step_t      step_reg;
    pcxrle_pkg::step_t      step_next;
    pcxrle_pkg::step_t      first_step;
    pcxrle_pkg::step_t      cur_step;
    pcxrle_pkg::step_t      after_step;
    logic                   done;
    logic                   issue;
    logic [7:0]             cur_byte;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [7:0]             code_byte_reg;
    logic [7:0]             code_byte_next;
    logic                   last_reg;
    logic                   last_next;

    assign out_valid = out_valid_reg;
    assign code_byte = code_byte_reg;
    assign last      = last_reg;

    always_comb
    begin
        priority if (head.run_a.vld)
        begin
            first_step = pcxrle_pkg::need_prefix(head.run_a) ?
                         pcxrle_pkg::STEP_A_PFX : pcxrle_pkg::STEP_A_VAL;
        end
        else if (head.run_b.vld)
        begin
            first_step = pcxrle_pkg::need_prefix(head.run_b) ?
                         pcxrle_pkg::STEP_B_PFX : pcxrle_pkg::STEP_B_VAL;
        end
        else
        begin
            first_step = pcxrle_pkg::STEP_PAD;
        end

        cur_step = mid_reg ? step_reg : first_step;

        after_step = pcxrle_pkg::STEP_PAD;
        done       = 1'b0;
        cur_byte   = 8'd0;
        unique case (cur_step)
            pcxrle_pkg::STEP_A_PFX:
            begin
                cur_byte   = pcxrle_pkg::HIGH_MARK | 8'(head.run_a.count);
                after_step = pcxrle_pkg::STEP_A_VAL;
            end
            pcxrle_pkg::STEP_A_VAL:
            begin
                cur_byte = head.run_a.value;
                priority if (head.run_b.vld)
                begin
                    after_step = pcxrle_pkg::need_prefix(head.run_b) ?
                                 pcxrle_pkg::STEP_B_PFX : pcxrle_pkg::STEP_B_VAL;
                end
                else if (head.pad)
                begin
                    after_step = pcxrle_pkg::STEP_PAD;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            pcxrle_pkg::STEP_B_PFX:
            begin
                cur_byte   = pcxrle_pkg::HIGH_MARK | 8'(head.run_b.count);
                after_step = pcxrle_pkg::STEP_B_VAL;
            end
            pcxrle_pkg::STEP_B_VAL:
            begin
                cur_byte   = head.run_b.value;
                after_step = pcxrle_pkg::STEP_PAD;
                done       = !head.pad;
            end
            pcxrle_pkg::STEP_PAD:
            begin
                cur_byte = 8'd0;
                done     = 1'b1;
            end
            default:
            begin
                cur_byte = 8'd0;
                done     = 1'b1;
            end
        endcase

        issue = head_valid && (!out_valid_reg || out_ready);
        pop   = issue && done;

        mid_next       = mid_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        code_byte_next = code_byte_reg;
        last_next      = last_reg;
        if (issue)
        begin
            out_valid_next = 1'b1;
            code_byte_next = cur_byte;
            last_next      = done;
            mid_next       = !done;
            step_next      = after_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg       <= 1'b0;
            step_reg      <= pcxrle_pkg::STEP_A_PFX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mid_reg       <= mid_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_byte_reg <= code_byte_next;
        last_reg      <= last_next;
    end

    `ASSERT_IMPLIES(a_mid_needs_head, mid_reg, head_valid,
        "request dropped part way through expansion")
    `ASSERT_NEXT(a_pop_marks_last, pop, out_valid_reg && last_reg,
        "request retired without a last byte")

endmodule

// ===== rtl/pcx_rle_line_encoder_unit.sv =====
// Top level of the run-length line encoder.
// Takes one pixel byte per request and produces its code bytes, one byte per
// cycle at the output while out_ready is high; a pixel that only extends the
// open run produces none. The front end accepts a pixel whenever the
// two-entry request queue has room, so it can take new pixels while the byte
// sequencer is still expanding earlier ones; the sequencer drains one byte
// per cycle while out_ready is high. A pixel that closes a line with pad
// enabled causes up to five code bytes.
// The pad setting may be written at any time the block is idle.

module pcx_rle_line_encoder_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] pixel,
    input  logic       line_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] code_byte,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    logic             q_full;
    logic             q_push;
    pcxrle_pkg::cmd_t q_cmd;
    logic             head_valid;
    pcxrle_pkg::cmd_t head;
    logic             pop;

    pcxrle_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel     (pixel),
        .line_end  (line_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    pcxrle_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    pcxrle_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_byte  (code_byte),
        .last       (last)
    );

endmodule
